[src/mhd_pkg.sv]
// ----------------------------------------------------------------------------
// mhd_pkg: shared types and constants for the marker pose heading block
// Holds the transfer payload structs, unit status struct, label codes,
// derived datapath widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package mhd_pkg;

  // Coordinate width of one corner and of one stored position.
  localparam int unsigned COORD_BITS = 11;

  // Rear-to-front and midpoint-to-target differences (doubled), signed.
  localparam int unsigned DIFF_W = COORD_BITS + 2;
  // One signed product of two differences.
  localparam int unsigned PROD_W = 2 * DIFF_W;
  // Dot and cross product accumulators, signed.
  localparam int unsigned ACC_W = PROD_W + 1;
  // Radicand for the distance: 64 times the sum of squares.
  localparam int unsigned SQ_W = PROD_W + 6;
  // Integer square root width.
  localparam int unsigned ROOT_W = SQ_W / 2;

  // CORDIC datapath: vector components, angle accumulator, step count.
  localparam int unsigned CW = 46;
  localparam int unsigned ZW = 26;
  localparam int unsigned CORDIC_STEPS = 23;
  localparam int unsigned STEP_W = 5;
  // Normalization: shift until one component reaches 2^NORM_TARGET_BIT.
  localparam int unsigned NORM_TARGET_BIT = 40;
  localparam int unsigned NORM_COARSE_BIT = 32;
  localparam int unsigned NORM_COARSE_SHIFT = 8;
  // Guard bound for the normalized vector.
  localparam int unsigned NORM_GUARD_BIT = 41;
  // Angle table fraction bits (1/65536 degree) and 180 degrees in those units.
  localparam int unsigned TAB_FRAC = 16;
  localparam logic signed [ZW-1:0] Z_HALF_TURN = 26'sd11796480;

  // Output saturation limits.
  localparam int unsigned HEAD_POS_MAX = 32767;
  localparam int unsigned HEAD_NEG_MAX = 32768;
  localparam int unsigned DIST_MAX = 65535;

  // Marker label codes.
  typedef enum logic [1:0] {
    LABEL_FRONT   = 2'd0,
    LABEL_REAR    = 2'd1,
    LABEL_TARGET  = 2'd2,
    LABEL_UNKNOWN = 2'd3
  } label_e;

  // Input item.
  typedef struct packed {
    logic [1:0]            marker_label;
    logic [COORD_BITS-1:0] corner_x0;
    logic [COORD_BITS-1:0] corner_y0;
    logic [COORD_BITS-1:0] corner_x1;
    logic [COORD_BITS-1:0] corner_y1;
    logic [COORD_BITS-1:0] corner_x2;
    logic [COORD_BITS-1:0] corner_y2;
    logic [COORD_BITS-1:0] corner_x3;
    logic [COORD_BITS-1:0] corner_y3;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [15:0] heading_error;
    logic [15:0]        target_distance;
    logic               all_markers_seen;
  } out_item_t;

  // Status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  // atan(2^-idx) in units of 1/65536 degree.
  function automatic logic [21:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic [21:0] val;
    case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      5'd20:   val = 22'd4;
      5'd21:   val = 22'd2;
      5'd22:   val = 22'd1;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[src/mhd_cordic.sv]
// ----------------------------------------------------------------------------
// mhd_cordic: iterative CORDIC vectoring unit for atan2
// Folds the vector into the right half plane, normalizes it with coarse and
// single-bit shifts, runs one micro-rotation per cycle and rounds the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module mhd_cordic #(
  parameter int unsigned ANGLE_FRAC_BITS = 7
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic signed [mhd_pkg::ACC_W-1:0] x_i,
  input  wire logic signed [mhd_pkg::ACC_W-1:0] y_i,
  output mhd_pkg::unit_status_t                 status_o,
  output logic signed [15:0]                    angle_o
);

  localparam int unsigned CW = mhd_pkg::CW;
  localparam int unsigned ZW = mhd_pkg::ZW;
  localparam int unsigned SH = mhd_pkg::TAB_FRAC - ANGLE_FRAC_BITS;

  typedef enum logic [3:0] {
    CS_IDLE = 4'b0001,
    CS_NORM = 4'b0010,
    CS_ROT  = 4'b0100,
    CS_DONE = 4'b1000
  } cordic_state_e;

  cordic_state_e cs_q, cs_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [mhd_pkg::STEP_W-1:0] step_q, step_d;

  logic signed [CW-1:0] x_ext, y_ext, ax, ay, xs, ys;
  logic signed [ZW-1:0] tab;
  logic coarse_ok, fine_ok, y_pos;

  // Sign-extended inputs.
  assign x_ext = CW'(x_i);
  assign y_ext = CW'(y_i);

  // Magnitudes for the normalization tests.
  assign ax = x_q[CW-1] ? -x_q : x_q;
  assign ay = y_q[CW-1] ? -y_q : y_q;
  assign coarse_ok = (ax[CW-1:mhd_pkg::NORM_COARSE_BIT] == '0) &&
                     (ay[CW-1:mhd_pkg::NORM_COARSE_BIT] == '0);
  assign fine_ok   = (ax[CW-1:mhd_pkg::NORM_TARGET_BIT] == '0) &&
                     (ay[CW-1:mhd_pkg::NORM_TARGET_BIT] == '0);

  // Shared micro-rotation datapath.
  assign xs    = x_q >>> step_q;
  assign ys    = y_q >>> step_q;
  assign tab   = ZW'(mhd_pkg::atan_entry(step_q));
  assign y_pos = !y_q[CW-1] && (y_q != '0);

  // Sequencer.
  always_comb begin
    cs_d   = cs_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    case (cs_q)
      CS_IDLE, CS_DONE: begin
        if (start_i) begin
          step_d = '0;
          if (x_i == '0 && y_i == '0) begin
            z_d  = '0;
            cs_d = CS_DONE;
          end else if (x_i[mhd_pkg::ACC_W-1]) begin
            z_d  = y_i[mhd_pkg::ACC_W-1] ? -mhd_pkg::Z_HALF_TURN : mhd_pkg::Z_HALF_TURN;
            x_d  = -x_ext;
            y_d  = -y_ext;
            cs_d = CS_NORM;
          end else begin
            z_d  = '0;
            x_d  = x_ext;
            y_d  = y_ext;
            cs_d = CS_NORM;
          end
        end
      end
      CS_NORM: begin
        if (coarse_ok) begin
          x_d = x_q <<< mhd_pkg::NORM_COARSE_SHIFT;
          y_d = y_q <<< mhd_pkg::NORM_COARSE_SHIFT;
        end else if (fine_ok) begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
        end else begin
          cs_d = CS_ROT;
        end
      end
      CS_ROT: begin
        if (y_pos) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + tab;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - tab;
        end
        step_d = step_q + 1'b1;
        if (step_q == mhd_pkg::STEP_W'(mhd_pkg::CORDIC_STEPS - 1)) begin
          cs_d = CS_DONE;
        end
      end
      default: cs_d = CS_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q   <= CS_IDLE;
      step_q <= '0;
    end else begin
      cs_q   <= cs_d;
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign status_o.busy = (cs_q == CS_NORM) || (cs_q == CS_ROT);
  assign status_o.done = (cs_q == CS_DONE);

  // Round the angle to the output unit, ties away from zero, and saturate.
  logic            z_neg;
  logic [ZW-1:0]   z_mag, z_rnd, z_lim, z_clip;
  logic [15:0]     mag16;

  assign z_neg  = z_q[ZW-1];
  assign z_mag  = z_neg ? ZW'(-z_q) : ZW'(z_q);
  assign z_rnd  = (z_mag + (ZW'(1) << (SH - 1))) >> SH;
  assign z_lim  = z_neg ? ZW'(mhd_pkg::HEAD_NEG_MAX) : ZW'(mhd_pkg::HEAD_POS_MAX);
  assign z_clip = (z_rnd > z_lim) ? z_lim : z_rnd;
  assign mag16  = z_clip[15:0];
  assign angle_o = z_neg ? $signed(16'd0 - mag16) : $signed(mag16);

  // The x component never goes negative once vectoring has started.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cs_q == CS_ROT) |-> !x_q[CW-1])
    else $error("cordic x component went negative during rotation");

  // Normalization never pushes a component past the guard bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cs_q == CS_NORM) |-> (ax[CW-1:mhd_pkg::NORM_GUARD_BIT] == '0) &&
                          (ay[CW-1:mhd_pkg::NORM_GUARD_BIT] == '0))
    else $error("cordic normalization overshoot");

  // The last micro-rotation ends the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cs_q == CS_ROT) && (step_q == mhd_pkg::STEP_W'(mhd_pkg::CORDIC_STEPS - 1))
      |=> (cs_q == CS_DONE))
    else $error("cordic did not finish after the last step");

endmodule

`default_nettype wire

[src/mhd_isqrt.sv]
// ----------------------------------------------------------------------------
// mhd_isqrt: iterative integer square root with round to nearest
// Digit-by-digit restoring square root, one result bit per cycle; the final
// remainder decides the rounding step.
// ----------------------------------------------------------------------------
`default_nettype none

module mhd_isqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [mhd_pkg::SQ_W-1:0]  radicand_i,
  output mhd_pkg::unit_status_t          status_o,
  output logic [15:0]                    dist_o
);

  localparam int unsigned SQ_W   = mhd_pkg::SQ_W;
  localparam int unsigned ROOT_W = mhd_pkg::ROOT_W;
  localparam int unsigned CNT_W  = $clog2(ROOT_W + 1);
  localparam int unsigned DW     = ROOT_W + 1;

  typedef enum logic [2:0] {
    QS_IDLE = 3'b001,
    QS_RUN  = 3'b010,
    QS_DONE = 3'b100
  } sqrt_state_e;

  sqrt_state_e qs_q, qs_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic [ROOT_W+1:0] rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;

  logic [ROOT_W+3:0] rem_sh, trial, diff;
  logic              ge;

  // One root digit per cycle.
  assign rem_sh = {rem_q, sq_q[SQ_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  // Sequencer.
  always_comb begin
    qs_d   = qs_q;
    cnt_d  = cnt_q;
    sq_d   = sq_q;
    rem_d  = rem_q;
    root_d = root_q;
    case (qs_q)
      QS_IDLE, QS_DONE: begin
        if (start_i) begin
          sq_d   = radicand_i;
          rem_d  = '0;
          root_d = '0;
          cnt_d  = '0;
          qs_d   = QS_RUN;
        end
      end
      QS_RUN: begin
        sq_d   = sq_q << 2;
        rem_d  = ge ? diff[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
        root_d = {root_q[ROOT_W-2:0], ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          qs_d = QS_DONE;
        end
      end
      default: qs_d = QS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qs_q  <= QS_IDLE;
      cnt_q <= '0;
    end else begin
      qs_q  <= qs_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign status_o.busy = (qs_q == QS_RUN);
  assign status_o.done = (qs_q == QS_DONE);

  // Round up when the remainder exceeds the root, then saturate.
  logic          round_up;
  logic [DW-1:0] dist_full;

  assign round_up  = (rem_q > {2'b00, root_q});
  assign dist_full = {1'b0, root_q} + DW'(round_up);
  assign dist_o    = (dist_full > DW'(mhd_pkg::DIST_MAX)) ? 16'hFFFF : dist_full[15:0];

  // The remainder of a finished root never exceeds twice the root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qs_q == QS_DONE) |-> (rem_q <= {1'b0, root_q, 1'b0}))
    else $error("isqrt remainder out of bound");

  // The last root digit ends the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qs_q == QS_RUN) && (cnt_q == CNT_W'(ROOT_W - 1)) |=> (qs_q == QS_DONE))
    else $error("isqrt did not finish after the last digit");

  // Starting loads a fresh run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && (qs_q != QS_RUN) |=> (qs_q == QS_RUN) && (cnt_q == '0))
    else $error("isqrt start not taken");

endmodule

`default_nettype wire

[src/marker_pose_heading_distance_top.sv]
// Latency: the result waits on the normalizing shifts and 23 CORDIC micro-rotations,
//   or on the 16 root digits when the dot and cross products are both zero.
// Throughput: one item at a time; the next input can be taken in the cycle after
//   the result is loaded into the output register, which waits for a free slot.
// Reset: rst_ni clears all three stored marker positions to zero.
// ----------------------------------------------------------------------------
// marker_pose_heading_distance_top: robot heading error and target distance
// Stores marker centroids, forms dot, cross and squared length with one
// shared multiplier, then runs the CORDIC and square root units.
// ----------------------------------------------------------------------------
`default_nettype none

module marker_pose_heading_distance_top #(
  parameter int unsigned ANGLE_FRAC_BITS = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mhd_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output mhd_pkg::out_item_t     out_data_o
);

  localparam int unsigned CB     = mhd_pkg::COORD_BITS;
  localparam int unsigned DIFF_W = mhd_pkg::DIFF_W;
  localparam int unsigned PROD_W = mhd_pkg::PROD_W;
  localparam int unsigned ACC_W  = mhd_pkg::ACC_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIFF  = 6'b000010,
    S_MUL   = 6'b000100,
    S_START = 6'b001000,
    S_WAIT  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  typedef enum logic [2:0] {
    MS_DOT_X   = 3'd0,
    MS_DOT_Y   = 3'd1,
    MS_CROSS_X = 3'd2,
    MS_CROSS_Y = 3'd3,
    MS_SQ_X    = 3'd4,
    MS_SQ_Y    = 3'd5
  } mul_step_e;

  state_e    state_q, state_d;
  mul_step_e mul_q, mul_d;

  logic [CB-1:0] front_x_q, front_y_q, rear_x_q, rear_y_q, target_x_q, target_y_q;
  logic signed [DIFF_W-1:0] rx_q, ry_q, dx2_q, dy2_q;
  logic signed [ACC_W-1:0]  dot_q, dot_d, cross_q, cross_d;
  logic [PROD_W-1:0]        ssq_q, ssq_d;
  logic                     out_valid_q, out_valid_d;
  mhd_pkg::out_item_t       out_q;

  logic in_xfer, out_load;
  logic [CB+1:0] sum_x, sum_y;
  logic [CB-1:0] cen_x, cen_y;

  mhd_pkg::unit_status_t cordic_status, sqrt_status;
  logic signed [15:0]    angle;
  logic [15:0]           dist_val;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Centroid of the four corners, truncated.
  assign sum_x = {2'b00, in_data_i.corner_x0} + {2'b00, in_data_i.corner_x1} +
                 {2'b00, in_data_i.corner_x2} + {2'b00, in_data_i.corner_x3};
  assign sum_y = {2'b00, in_data_i.corner_y0} + {2'b00, in_data_i.corner_y1} +
                 {2'b00, in_data_i.corner_y2} + {2'b00, in_data_i.corner_y3};
  assign cen_x = sum_x[CB+1:2];
  assign cen_y = sum_y[CB+1:2];

  // Stored marker positions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_x_q  <= '0;
      front_y_q  <= '0;
      rear_x_q   <= '0;
      rear_y_q   <= '0;
      target_x_q <= '0;
      target_y_q <= '0;
    end else if (in_xfer) begin
      case (in_data_i.marker_label)
        mhd_pkg::LABEL_FRONT: begin
          front_x_q <= cen_x;
          front_y_q <= cen_y;
        end
        mhd_pkg::LABEL_REAR: begin
          rear_x_q <= cen_x;
          rear_y_q <= cen_y;
        end
        mhd_pkg::LABEL_TARGET: begin
          target_x_q <= cen_x;
          target_y_q <= cen_y;
        end
        default: begin
        end
      endcase
    end
  end

  // Robot direction and doubled midpoint-to-target vector.
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIFF) begin
      rx_q  <= $signed({2'b00, front_x_q}) - $signed({2'b00, rear_x_q});
      ry_q  <= $signed({2'b00, front_y_q}) - $signed({2'b00, rear_y_q});
      dx2_q <= $signed({1'b0, target_x_q, 1'b0} - ({2'b00, front_x_q} + {2'b00, rear_x_q}));
      dy2_q <= $signed({1'b0, target_y_q, 1'b0} - ({2'b00, front_y_q} + {2'b00, rear_y_q}));
    end
  end

  // Shared multiplier with accumulation, one product per cycle.
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    case (mul_q)
      MS_DOT_X:   begin mul_a = rx_q;  mul_b = dx2_q; end
      MS_DOT_Y:   begin mul_a = ry_q;  mul_b = dy2_q; end
      MS_CROSS_X: begin mul_a = rx_q;  mul_b = dy2_q; end
      MS_CROSS_Y: begin mul_a = ry_q;  mul_b = dx2_q; end
      MS_SQ_X:    begin mul_a = dx2_q; mul_b = dx2_q; end
      MS_SQ_Y:    begin mul_a = dy2_q; mul_b = dy2_q; end
      default:    begin mul_a = '0;    mul_b = '0;    end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    dot_d   = dot_q;
    cross_d = cross_q;
    ssq_d   = ssq_q;
    case (mul_q)
      MS_DOT_X:   dot_d   = ACC_W'(prod);
      MS_DOT_Y:   dot_d   = dot_q + ACC_W'(prod);
      MS_CROSS_X: cross_d = ACC_W'(prod);
      MS_CROSS_Y: cross_d = cross_q - ACC_W'(prod);
      MS_SQ_X:    ssq_d   = PROD_W'(prod);
      MS_SQ_Y:    ssq_d   = ssq_q + PROD_W'(prod);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      dot_q   <= dot_d;
      cross_q <= cross_d;
      ssq_q   <= ssq_d;
    end
  end

  // Main sequencer.
  always_comb begin
    state_d = state_q;
    mul_d   = mul_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        mul_d   = MS_DOT_X;
        state_d = S_MUL;
      end
      S_MUL: begin
        mul_d = mul_step_e'(mul_q + 3'd1);
        if (mul_q == MS_SQ_Y) begin
          state_d = S_START;
        end
      end
      S_START: state_d = S_WAIT;
      S_WAIT: begin
        if (cordic_status.done && sqrt_status.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mul_q   <= MS_DOT_X;
    end else begin
      state_q <= state_d;
      mul_q   <= mul_d;
    end
  end

  // Arithmetic units.
  mhd_cordic #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_START),
    .x_i     (dot_q),
    .y_i     (cross_q),
    .status_o(cordic_status),
    .angle_o (angle)
  );

  mhd_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == S_START),
    .radicand_i({ssq_q, 6'b000000}),
    .status_o  (sqrt_status),
    .dist_o    (dist_val)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.heading_error    <= angle;
      out_q.target_distance  <= dist_val;
      out_q.all_markers_seen <= (front_x_q != '0) && (rear_x_q != '0) &&
                                (target_x_q != '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An accepted item keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  // While waiting, both units are working or finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> (cordic_status.busy || cordic_status.done) &&
                            (sqrt_status.busy || sqrt_status.done))
    else $error("arithmetic unit idle while waited on");

  // Loading a result always presents it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && (state_q == S_IDLE))
    else $error("result load not presented");

endmodule

`default_nettype wire

[verif/marker_pose_heading_distance_checker.sv]
// ----------------------------------------------------------------------------
// marker_pose_heading_distance_checker: result predictor and scoreboard
// Watches both channels of the marker pose block. Every input transfer
// updates a private copy of the stored marker positions and queues the
// heading error, target distance and all-seen flag that the block must
// return. Every output transfer is compared with the oldest queued result.
// ----------------------------------------------------------------------------
`default_nettype none

module marker_pose_heading_distance_checker #(
  parameter int unsigned ANGLE_FRAC_BITS = 7
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire mhd_pkg::in_item_t  in_data_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire mhd_pkg::out_item_t out_data_i,
  output logic [31:0]             fail_count_o,
  output logic [31:0]             pending_o
);

  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned ROTATIONS    = 23;
  localparam longint      HALF_TURN    = longint'(180) << mhd_pkg::TAB_FRAC;
  localparam longint      SCALE_LIMIT  = longint'(1) << 40;

  typedef logic [mhd_pkg::COORD_BITS-1:0] coord_t;

  // Private copy of the stored marker positions.
  coord_t front_x, front_y, rear_x, rear_y, target_x, target_y;

  mhd_pkg::out_item_t pose_results_q[$];
  mhd_pkg::out_item_t wanted;
  logic [31:0]        mismatch_cnt;

  // Elementary rotation angles atan(2^-i), in 1/65536 degree.
  function automatic longint rotation_angle(input int unsigned idx);
    case (idx)
      0:       return 2949120;
      1:       return 1740967;
      2:       return 919879;
      3:       return 466945;
      4:       return 234379;
      5:       return 117304;
      6:       return 58666;
      7:       return 29335;
      8:       return 14668;
      9:       return 7334;
      10:      return 3667;
      11:      return 1833;
      12:      return 917;
      13:      return 458;
      14:      return 229;
      15:      return 115;
      16:      return 57;
      17:      return 29;
      18:      return 14;
      19:      return 7;
      20:      return 4;
      21:      return 2;
      22:      return 1;
      default: return 0;
    endcase
  endfunction

  // Centroid coordinate of four corners, truncated.
  function automatic coord_t corner_mean(input coord_t a, input coord_t b,
                                         input coord_t c, input coord_t d);
    logic [mhd_pkg::COORD_BITS+1:0] total;
    total = a + b + c + d;
    return total[mhd_pkg::COORD_BITS+1:2];
  endfunction

  // Vectoring CORDIC: angle of (x, y) in 1/65536 degree.
  function automatic longint vector_angle(input longint y, input longint x);
    longint      z;
    longint      xs;
    longint      ys;
    int unsigned i;
    z = 0;
    if (x == 0 && y == 0) begin
      return 0;
    end
    // Fold the left half plane onto the right one.
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    // Scale up until one component reaches the working magnitude.
    while ((x < 0 ? -x : x) < SCALE_LIMIT && (y < 0 ? -y : y) < SCALE_LIMIT) begin
      x = x * 2;
      y = y * 2;
    end
    for (i = 0; i < ROTATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + rotation_angle(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - rotation_angle(i);
      end
    end
    return z;
  endfunction

  // Exact integer square root, bit by bit.
  function automatic longint unsigned exact_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) begin
      probe = probe >> 2;
    end
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Heading error, target distance and all-seen flag for the stored pose.
  function automatic mhd_pkg::out_item_t pose_from_markers(input coord_t fx, input coord_t fy,
                                                           input coord_t bx, input coord_t by,
                                                           input coord_t tx, input coord_t ty);
    longint             dir_x, dir_y, off_x, off_y, dot_p, cross_p, ang;
    longint unsigned    mag, radicand, root, range_val;
    int unsigned        drop;
    mhd_pkg::out_item_t res;
    dir_x   = longint'(fx) - longint'(bx);
    dir_y   = longint'(fy) - longint'(by);
    off_x   = 2 * longint'(tx) - (longint'(fx) + longint'(bx));
    off_y   = 2 * longint'(ty) - (longint'(fy) + longint'(by));
    dot_p   = dir_x * off_x + dir_y * off_y;
    cross_p = dir_x * off_y - dir_y * off_x;

    // Round the angle to the output resolution, then saturate.
    ang  = vector_angle(cross_p, dot_p);
    mag  = (ang < 0) ? longint'(-ang) : longint'(ang);
    drop = mhd_pkg::TAB_FRAC - ANGLE_FRAC_BITS;
    if (drop > 0) begin
      mag = (mag + (64'd1 << (drop - 1))) >> drop;
    end
    if (ang < 0) begin
      if (mag > mhd_pkg::HEAD_NEG_MAX) mag = mhd_pkg::HEAD_NEG_MAX;
      res.heading_error = 16'(-mag);
    end else begin
      if (mag > mhd_pkg::HEAD_POS_MAX) mag = mhd_pkg::HEAD_POS_MAX;
      res.heading_error = 16'(mag);
    end

    // Distance in 1/16 pixel from the doubled offset, rounded to nearest.
    radicand  = 64 * (longint'(off_x * off_x) + longint'(off_y * off_y));
    root      = exact_root(radicand);
    range_val = (radicand - root * root > root) ? root + 1 : root;
    if (range_val > mhd_pkg::DIST_MAX) range_val = mhd_pkg::DIST_MAX;
    res.target_distance  = 16'(range_val);
    res.all_markers_seen = (fx != 0) && (bx != 0) && (tx != 0);
    return res;
  endfunction

  // Compare output transfers, then predict from input transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_x      = '0;
      front_y      = '0;
      rear_x       = '0;
      rear_y       = '0;
      target_x     = '0;
      target_y     = '0;
      mismatch_cnt = '0;
      pose_results_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pose_results_q.size() == 0) begin
          if (mismatch_cnt < REPORT_MAX) begin
            $display("[%0t] unexpected result: heading %0d distance %0d seen %0b",
                     $realtime, out_data_i.heading_error, out_data_i.target_distance,
                     out_data_i.all_markers_seen);
          end
          mismatch_cnt = mismatch_cnt + 1;
        end else begin
          wanted = pose_results_q.pop_front();
          if (out_data_i.heading_error !== wanted.heading_error ||
              out_data_i.target_distance !== wanted.target_distance ||
              out_data_i.all_markers_seen !== wanted.all_markers_seen) begin
            if (mismatch_cnt < REPORT_MAX) begin
              $display("[%0t] mismatch: heading exp %0d got %0d, ",
                       $realtime, wanted.heading_error, out_data_i.heading_error,
                       "distance exp %0d got %0d, ",
                       wanted.target_distance, out_data_i.target_distance,
                       "seen exp %0b got %0b",
                       wanted.all_markers_seen, out_data_i.all_markers_seen);
            end
            mismatch_cnt = mismatch_cnt + 1;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        // An unknown label leaves every stored position as it is.
        if (in_data_i.marker_label == mhd_pkg::LABEL_FRONT) begin
          front_x = corner_mean(in_data_i.corner_x0, in_data_i.corner_x1,
                                in_data_i.corner_x2, in_data_i.corner_x3);
          front_y = corner_mean(in_data_i.corner_y0, in_data_i.corner_y1,
                                in_data_i.corner_y2, in_data_i.corner_y3);
        end else if (in_data_i.marker_label == mhd_pkg::LABEL_REAR) begin
          rear_x = corner_mean(in_data_i.corner_x0, in_data_i.corner_x1,
                               in_data_i.corner_x2, in_data_i.corner_x3);
          rear_y = corner_mean(in_data_i.corner_y0, in_data_i.corner_y1,
                               in_data_i.corner_y2, in_data_i.corner_y3);
        end else if (in_data_i.marker_label == mhd_pkg::LABEL_TARGET) begin
          target_x = corner_mean(in_data_i.corner_x0, in_data_i.corner_x1,
                                 in_data_i.corner_x2, in_data_i.corner_x3);
          target_y = corner_mean(in_data_i.corner_y0, in_data_i.corner_y1,
                                 in_data_i.corner_y2, in_data_i.corner_y3);
        end
        pose_results_q.push_back(pose_from_markers(front_x, front_y, rear_x, rear_y,
                                                   target_x, target_y));
      end
    end
    pending_o    = pose_results_q.size();
    fail_count_o = mismatch_cnt;
  end

endmodule

`default_nettype wire

[verif/marker_pose_heading_distance_top_test.sv]
// ----------------------------------------------------------------------------
// marker_pose_heading_distance_top_test: stimulus and verdict for the block
// Drives a directed set of marker scenes, then random robot scenes mixed
// with noise markers under four idling patterns, a long output hold-off
// and drain pauses. A checker instance beside the block scores the results.
// ----------------------------------------------------------------------------
`default_nettype none

module marker_pose_heading_distance_top_test;

  localparam int unsigned ANGLE_FRAC     = 7;
  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned RANDOM_ITEMS   = 1750;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned CB             = mhd_pkg::COORD_BITS;
  localparam int          COORD_MAX      = (1 << CB) - 1;

  typedef logic [CB-1:0] coord_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  mhd_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  mhd_pkg::out_item_t out_data;
  logic [31:0]        fail_cnt;
  logic [31:0]        pending;
  logic               in_taken = 1'b0;
  logic               hold_pending = 1'b0;
  idle_mode_e         idle_mode = IDLE_NONE;

  marker_pose_heading_distance_top #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  marker_pose_heading_distance_checker #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC)
  ) scoreboard (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_cnt),
    .pending_o    (pending)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Remember whether the last rising edge completed an input transfer.
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
  end

  // Receiver: random stalls per idling mode, plus one long hold-off on request.
  initial begin : receiver
    int unsigned held;
    int unsigned stall_pct;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) begin
          @(negedge clk);
        end
        hold_pending = 1'b0;
      end else begin
        stall_pct = (idle_mode == IDLE_RECV) ? 63 : (idle_mode == IDLE_BOTH) ? 26 : 0;
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Corner coordinate near c, kept inside the coordinate range.
  function automatic coord_t near_coord(input int c, input int spread);
    int v;
    v = c + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v[CB-1:0];
  endfunction

  // Marker whose corners lie within spread pixels of (x, y).
  function automatic mhd_pkg::in_item_t marker_at(input mhd_pkg::label_e label, input int x,
                                                  input int y, input int spread);
    mhd_pkg::in_item_t item;
    item.marker_label = label;
    item.corner_x0    = near_coord(x, spread);
    item.corner_y0    = near_coord(y, spread);
    item.corner_x1    = near_coord(x, spread);
    item.corner_y1    = near_coord(y, spread);
    item.corner_x2    = near_coord(x, spread);
    item.corner_y2    = near_coord(y, spread);
    item.corner_x3    = near_coord(x, spread);
    item.corner_y3    = near_coord(y, spread);
    return item;
  endfunction

  // Marker with every field drawn at random.
  function automatic mhd_pkg::in_item_t noise_marker();
    mhd_pkg::in_item_t item;
    item.marker_label = mhd_pkg::label_e'($urandom_range(3));
    item.corner_x0    = coord_t'($urandom_range(COORD_MAX));
    item.corner_y0    = coord_t'($urandom_range(COORD_MAX));
    item.corner_x1    = coord_t'($urandom_range(COORD_MAX));
    item.corner_y1    = coord_t'($urandom_range(COORD_MAX));
    item.corner_x2    = coord_t'($urandom_range(COORD_MAX));
    item.corner_y2    = coord_t'($urandom_range(COORD_MAX));
    item.corner_x3    = coord_t'($urandom_range(COORD_MAX));
    item.corner_y3    = coord_t'($urandom_range(COORD_MAX));
    return item;
  endfunction

  // Offer one marker, wait for its transfer, then idle per the mode.
  task automatic send_marker(input mhd_pkg::in_item_t item);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 63 : (idle_mode == IDLE_BOTH) ? 26 : 0;
    in_valid <= 1'b1;
    in_data  <= item;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
  endtask

  // Hold the sender back until every queued result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Random robot scenes: front, rear and target in random order, with
  // stray unknown markers, exact behind-the-robot targets and pure noise.
  task automatic run_scenes(input int unsigned count);
    int unsigned sent;
    int          px[3];
    int          py[3];
    int          order;
    int          k;
    int          spread;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 20) begin
        send_marker(noise_marker());
        sent++;
      end else begin
        spread = ($urandom_range(3) == 0) ? 0 : $urandom_range(4);
        px[0]  = $urandom_range(COORD_MAX);
        py[0]  = $urandom_range(COORD_MAX);
        px[1]  = int'(near_coord(px[0], $urandom_range(300)));
        py[1]  = int'(near_coord(py[0], $urandom_range(300)));
        if ($urandom_range(9) == 0) begin
          // Target on the robot axis behind the rear marker.
          spread = 0;
          px[2]  = 2 * px[1] - px[0];
          py[2]  = 2 * py[1] - py[0];
          if (px[2] < 0 || px[2] > COORD_MAX || py[2] < 0 || py[2] > COORD_MAX) begin
            px[2] = px[1];
            py[2] = py[1];
          end
        end else begin
          px[2] = $urandom_range(COORD_MAX);
          py[2] = $urandom_range(COORD_MAX);
        end
        order = $urandom_range(2);
        for (k = 0; k < 3; k++) begin
          send_marker(marker_at(mhd_pkg::label_e'((k + order) % 3), px[(k + order) % 3],
                                py[(k + order) % 3], spread));
          sent++;
          if ($urandom_range(99) < 15) begin
            send_marker(marker_at(mhd_pkg::LABEL_UNKNOWN, $urandom_range(COORD_MAX),
                                  $urandom_range(COORD_MAX), 20));
            sent++;
          end
        end
      end
    end
  endtask

  // Main stimulus and verdict.
  initial begin : stimulus
    mhd_pkg::in_item_t item;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Nothing stored yet: zero vector and zero distance.
    send_marker(marker_at(mhd_pkg::LABEL_UNKNOWN, COORD_MAX, COORD_MAX, 0));
    // Robot pointing along +x, target ahead, behind, left, right, at midpoint.
    send_marker(marker_at(mhd_pkg::LABEL_FRONT, 1000, 1000, 0));
    send_marker(marker_at(mhd_pkg::LABEL_REAR, 900, 1000, 0));
    send_marker(marker_at(mhd_pkg::LABEL_TARGET, 1200, 1000, 0));
    send_marker(marker_at(mhd_pkg::LABEL_TARGET, 600, 1000, 0));
    send_marker(marker_at(mhd_pkg::LABEL_TARGET, 950, 1300, 0));
    send_marker(marker_at(mhd_pkg::LABEL_TARGET, 950, 700, 0));
    send_marker(marker_at(mhd_pkg::LABEL_TARGET, 950, 1000, 0));
    // Unknown markers leave the pose alone.
    send_marker(marker_at(mhd_pkg::LABEL_UNKNOWN, 10, 2000, 5));
    // Front and rear on the same spot.
    send_marker(marker_at(mhd_pkg::LABEL_REAR, 1000, 1000, 0));
    // Truncating centroid.
    item = marker_at(mhd_pkg::LABEL_TARGET, 0, 0, 0);
    item.corner_x0 = coord_t'(1);
    item.corner_x1 = coord_t'(2);
    item.corner_x2 = coord_t'(3);
    item.corner_x3 = coord_t'(3);
    item.corner_y3 = coord_t'(3);
    send_marker(item);
    // Coordinate extremes and the longest distance.
    send_marker(marker_at(mhd_pkg::LABEL_FRONT, 0, 0, 0));
    send_marker(marker_at(mhd_pkg::LABEL_REAR, 0, 0, 0));
    send_marker(marker_at(mhd_pkg::LABEL_TARGET, COORD_MAX, COORD_MAX, 0));
    send_marker(marker_at(mhd_pkg::LABEL_REAR, COORD_MAX, 0, 0));
    item = marker_at(mhd_pkg::LABEL_TARGET, 0, COORD_MAX, 0);
    item.corner_x1 = coord_t'(COORD_MAX);
    item.corner_x3 = coord_t'(COORD_MAX);
    item.corner_y2 = coord_t'(0);
    send_marker(item);
    send_marker(marker_at(mhd_pkg::LABEL_FRONT, COORD_MAX, COORD_MAX, 0));
    send_marker(marker_at(mhd_pkg::LABEL_REAR, 1, 1, 0));
    send_marker(marker_at(mhd_pkg::LABEL_TARGET, 1, COORD_MAX, 0));
    send_marker(marker_at(mhd_pkg::LABEL_UNKNOWN, 0, 0, 0));
    drain_results();

    // Random scenes under each idling pattern; the first one with a long
    // output hold-off so that the block backs up into its input.
    idle_mode    = IDLE_NONE;
    hold_pending = 1'b1;
    run_scenes(RANDOM_ITEMS / 4);
    drain_results();
    idle_mode = IDLE_SEND;
    run_scenes(RANDOM_ITEMS / 4);
    drain_results();
    idle_mode = IDLE_RECV;
    run_scenes(RANDOM_ITEMS / 4);
    drain_results();
    idle_mode = IDLE_BOTH;
    run_scenes(RANDOM_ITEMS / 4);
    drain_results();

    // Let any stray result surface before the verdict.
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
